@@ sv/bdll_pkg.sv @@
// shared definitions for the bounded doubly linked list core
// field widths, action codes and status codes; no dependencies
package bdll_pkg;

   localparam int DEFAULT_CAPACITY = 256;

   localparam int ACTION_W = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 8;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 9;

   localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_FIND   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_SIZE   = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

endpackage

@@ sv/bdll_if.sv @@
// request and response channel interfaces of the linked list core
// valid/ready handshake with payload; uses bdll_pkg widths
interface bdll_req_if;
   logic                                valid;
   logic                                ready;
   logic [bdll_pkg::ACTION_W-1:0]       action;
   logic signed [bdll_pkg::VALUE_W-1:0] item_value;
   logic [bdll_pkg::POS_W-1:0]          position;

   modport source (output valid, action, item_value, position, input ready);
   modport sink   (input valid, action, item_value, position, output ready);
endinterface

interface bdll_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [bdll_pkg::STATUS_W-1:0]       status;
   logic signed [bdll_pkg::VALUE_W-1:0] found_value;
   logic [bdll_pkg::POS_W-1:0]          found_position;
   logic [bdll_pkg::COUNT_W-1:0]        entry_count;

   modport source (output valid, status, found_value, found_position, entry_count,
                   input ready);
   modport sink   (input valid, status, found_value, found_position, entry_count,
                   output ready);
endinterface

@@ sv/bounded_doubly_linked_list_core.sv @@
// bounded doubly linked list: node memory, free-slot stack memory and sequencer
// depends on bdll_pkg and the channel interfaces in bdll_if.sv
//
//   channel   dir  handshake    payload
//   req_chan  in   valid/ready  action, item_value, position
//   rsp_chan  out  valid/ready  status, found_value, found_position, entry_count
//
// one request at a time; find, remove and read walk the list from the head,
// and remove then makes up to 2 link writes; the walk is bound by the node
// memory read port, one link per cycle.
// reset clears the pointers and counts at once; the free stack's initial
// order is implied by a watermark, so there is no clearing pass.
// a new request is taken while the previous response still waits in the
// output register; a stalled response holds the sequencer before delivery.
module bounded_doubly_linked_list_core #(
   parameter int CAPACITY = bdll_pkg::DEFAULT_CAPACITY
) (
   input logic        clock,
   input logic        reset,
   bdll_req_if.sink   req_chan,
   bdll_rsp_if.source rsp_chan
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = CW + 8;

   localparam logic [2:0] S_IDLE        = 3'd0;
   localparam logic [2:0] S_TAKE        = 3'd1;
   localparam logic [2:0] S_LINK        = 3'd2;
   localparam logic [2:0] S_WALK        = 3'd3;
   localparam logic [2:0] S_UNLINK_NEXT = 3'd4;
   localparam logic [2:0] S_UNLINK_PREV = 3'd5;
   localparam logic [2:0] S_RESP        = 3'd6;

   // control state
   logic [2:0]    state_ff, state_in;
   logic [IW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] len_ff, len_in, free_ff, free_in, wm_ff, wm_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // request context
   logic [bdll_pkg::ACTION_W-1:0]       act_ff, act_in;
   logic signed [bdll_pkg::VALUE_W-1:0] val_ff, val_in;
   logic [bdll_pkg::POS_W-1:0]          pos_ff, pos_in;
   logic [IW-1:0]                       cur_ff, cur_in, nx_ff, nx_in, pv_ff, pv_in;
   logic [CW-1:0]                       k_ff, k_in;
   logic                                virgin_ff, virgin_in;
   logic                                first_ff, first_in, last_ff, last_in;

   logic [bdll_pkg::STATUS_W-1:0]       res_status_ff, res_status_in;
   logic signed [bdll_pkg::VALUE_W-1:0] res_value_ff, res_value_in;
   logic [bdll_pkg::POS_W-1:0]          res_pos_ff, res_pos_in;

   logic [bdll_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic signed [bdll_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [bdll_pkg::POS_W-1:0]          rsp_pos_ff, rsp_pos_in;
   logic [bdll_pkg::COUNT_W-1:0]        rsp_count_ff, rsp_count_in;

   // node memory: value, next and prev fields, one write and one read port
   logic signed [bdll_pkg::VALUE_W-1:0] val_mem [CAPACITY];
   logic [IW-1:0]                       nxt_mem [CAPACITY];
   logic [IW-1:0]                       prv_mem [CAPACITY];
   logic signed [bdll_pkg::VALUE_W-1:0] rd_val_ff;
   logic [IW-1:0]                       rd_nxt_ff, rd_prv_ff;
   logic [IW-1:0]                       nr_addr, nw_addr, nw_nxt, nw_prv;
   logic                                we_val, we_nxt, we_prv;

   // free-slot stack memory
   logic [IW-1:0] stk_mem [CAPACITY];
   logic [IW-1:0] stk_rd_ff;
   logic [IW-1:0] pop_idx, push_idx, new_slot;
   logic          stk_we;

   logic [EW-1:0] k_ext, pos_ext, len_ext, req_pos_ext;
   logic          accept;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && (state_ff == S_IDLE);

   assign pop_idx     = IW'(free_ff - CW'(1));
   assign push_idx    = IW'(free_ff);
   // entries below the watermark were never written since reset or clear
   assign new_slot    = virgin_ff ? pop_idx : stk_rd_ff;
   assign k_ext       = EW'(k_ff);
   assign pos_ext     = EW'(pos_ff);
   assign len_ext     = EW'(len_ff);
   assign req_pos_ext = EW'(req_chan.position);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      len_in        = len_ff;
      free_in       = free_ff;
      wm_in         = wm_ff;
      act_in        = act_ff;
      val_in        = val_ff;
      pos_in        = pos_ff;
      cur_in        = cur_ff;
      nx_in         = nx_ff;
      pv_in         = pv_ff;
      k_in          = k_ff;
      virgin_in     = virgin_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_pos_in    = res_pos_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      nr_addr       = cur_ff;
      nw_addr       = cur_ff;
      nw_nxt        = '0;
      nw_prv        = '0;
      we_val        = 1'b0;
      we_nxt        = 1'b0;
      we_prv        = 1'b0;
      stk_we        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            nr_addr = head_ff;
            if (accept) begin
               act_in        = req_chan.action;
               val_in        = req_chan.item_value;
               pos_in        = req_chan.position;
               cur_in        = head_ff;
               k_in          = '0;
               virgin_in     = (free_ff == wm_ff);
               res_status_in = bdll_pkg::ST_OK;
               res_value_in  = '0;
               res_pos_in    = '0;
               state_in      = S_RESP;
               case (req_chan.action)
                  bdll_pkg::ACT_APPEND, bdll_pkg::ACT_INSERT: begin
                     if (free_ff == '0) begin
                        res_status_in = bdll_pkg::ST_FULL;
                     end else begin
                        state_in = S_TAKE;
                     end
                  end
                  bdll_pkg::ACT_REMOVE, bdll_pkg::ACT_FIND: begin
                     if (len_ff == '0) begin
                        res_status_in = bdll_pkg::ST_EMPTY;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  bdll_pkg::ACT_READ: begin
                     if (len_ff == '0) begin
                        res_status_in = bdll_pkg::ST_EMPTY;
                     end else if (req_pos_ext >= len_ext) begin
                        res_status_in = bdll_pkg::ST_RANGE;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  bdll_pkg::ACT_CLEAR: begin
                     free_in = CW'(CAPACITY);
                     wm_in   = CW'(CAPACITY);
                     head_in = '0;
                     tail_in = '0;
                     len_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_TAKE: begin
            nw_addr = new_slot;
            we_val  = 1'b1;
            we_nxt  = 1'b1;
            we_prv  = 1'b1;
            free_in = free_ff - CW'(1);
            wm_in   = virgin_ff ? free_ff - CW'(1) : wm_ff;
            len_in  = len_ff + CW'(1);
            nx_in   = new_slot;
            if (len_ff == '0) begin
               head_in  = new_slot;
               tail_in  = new_slot;
               state_in = S_RESP;
            end else if (act_ff == bdll_pkg::ACT_APPEND) begin
               nw_prv   = tail_ff;
               tail_in  = new_slot;
               cur_in   = tail_ff;
               state_in = S_LINK;
            end else begin
               nw_nxt   = head_ff;
               head_in  = new_slot;
               cur_in   = head_ff;
               state_in = S_LINK;
            end
         end

         S_LINK: begin
            // hook the old end node to the new slot
            nw_addr = cur_ff;
            nw_nxt  = nx_ff;
            nw_prv  = nx_ff;
            if (act_ff == bdll_pkg::ACT_APPEND) begin
               we_nxt = 1'b1;
            end else begin
               we_prv = 1'b1;
            end
            state_in = S_RESP;
         end

         S_WALK: begin
            if (act_ff == bdll_pkg::ACT_READ) begin
               if (k_ext == pos_ext) begin
                  res_value_in = rd_val_ff;
                  state_in     = S_RESP;
               end else begin
                  nr_addr = rd_nxt_ff;
                  cur_in  = rd_nxt_ff;
                  k_in    = k_ff + CW'(1);
               end
            end else if (rd_val_ff == val_ff) begin
               if (act_ff == bdll_pkg::ACT_FIND) begin
                  res_pos_in = k_ext[7:0];
                  state_in   = S_RESP;
               end else begin
                  nx_in    = rd_nxt_ff;
                  pv_in    = rd_prv_ff;
                  first_in = (k_ff == '0);
                  last_in  = ((k_ff + CW'(1)) == len_ff);
                  state_in = S_UNLINK_NEXT;
               end
            end else if ((k_ff + CW'(1)) == len_ff) begin
               res_status_in = bdll_pkg::ST_NOT_FOUND;
               state_in      = S_RESP;
            end else begin
               nr_addr = rd_nxt_ff;
               cur_in  = rd_nxt_ff;
               k_in    = k_ff + CW'(1);
            end
         end

         S_UNLINK_NEXT: begin
            nw_addr = pv_ff;
            nw_nxt  = nx_ff;
            we_nxt  = !first_ff;
            if (first_ff) begin
               head_in = nx_ff;
            end
            if (last_ff) begin
               tail_in = pv_ff;
            end
            stk_we  = 1'b1;
            free_in = free_ff + CW'(1);
            len_in  = len_ff - CW'(1);
            if (len_ff == CW'(1)) begin
               head_in = '0;
               tail_in = '0;
            end
            state_in = last_ff ? S_RESP : S_UNLINK_PREV;
         end

         S_UNLINK_PREV: begin
            nw_addr  = nx_ff;
            nw_prv   = pv_ff;
            we_prv   = 1'b1;
            state_in = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_pos_in    = res_pos_ff;
               rsp_count_in  = len_ext[8:0];
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         len_ff       <= '0;
         free_ff      <= CW'(CAPACITY);
         wm_ff        <= CW'(CAPACITY);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         len_ff       <= len_in;
         free_ff      <= free_in;
         wm_ff        <= wm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      cur_ff        <= cur_in;
      nx_ff         <= nx_in;
      pv_ff         <= pv_in;
      k_ff          <= k_in;
      virgin_ff     <= virgin_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_pos_ff    <= res_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (we_val) begin
         val_mem[nw_addr] <= val_ff;
      end
      if (we_nxt) begin
         nxt_mem[nw_addr] <= nw_nxt;
      end
      if (we_prv) begin
         prv_mem[nw_addr] <= nw_prv;
      end
      rd_val_ff <= val_mem[nr_addr];
      rd_nxt_ff <= nxt_mem[nr_addr];
      rd_prv_ff <= prv_mem[nr_addr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[push_idx] <= cur_ff;
      end
      stk_rd_ff <= stk_mem[pop_idx];
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.found_value    = rsp_value_ff;
   assign rsp_chan.found_position = rsp_pos_ff;
   assign rsp_chan.entry_count    = rsp_count_ff;

   // every slot is either linked or on the free stack
   assert property (@(posedge clock) disable iff (reset)
      ((CW + 1)'(len_ff) + (CW + 1)'(free_ff)) == (CW + 1)'(CAPACITY))
      else $error("slot accounting lost a slot");

   // written stack entries always lie at or above the watermark
   assert property (@(posedge clock) disable iff (reset) wm_ff <= free_ff)
      else $error("free stack watermark above stack pointer");

   // an empty list parks both end pointers at slot zero
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && len_ff == '0) |-> (head_ff == '0 && tail_ff == '0))
      else $error("empty list with stray end pointers");

   // a request that finds no free slot answers without touching the pool
   assert property (@(posedge clock) disable iff (reset)
      (accept && free_ff == '0 && (req_chan.action == bdll_pkg::ACT_APPEND ||
       req_chan.action == bdll_pkg::ACT_INSERT)) |=> (state_ff == S_RESP && free_ff == '0))
      else $error("full pool request changed state");

endmodule

@@ sim/bounded_doubly_linked_list_core_test.sv @@
// self-checking testbench for bounded_doubly_linked_list_core: directed list requests, then
// random mixes with a fill to capacity; depends on bdll_pkg and the channel interfaces
module bounded_doubly_linked_list_core_test;

   localparam int CAPACITY      = bdll_pkg::DEFAULT_CAPACITY;
   localparam int RANDOM_ITEMS  = 1000;
   localparam int STALL_LIMIT   = 20000;
   localparam int PRESSURE_AT   = 200;
   localparam int PRESSURE_HOLD = 1500;

   localparam logic [bdll_pkg::ACTION_W-1:0] ACT_UNUSED = 3'd7;
   localparam logic signed [bdll_pkg::VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [bdll_pkg::VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

   // action order for the per-mix cut tables
   localparam logic [bdll_pkg::ACTION_W-1:0] MIX_ACTIONS [8] = '{bdll_pkg::ACT_APPEND,
      bdll_pkg::ACT_INSERT, bdll_pkg::ACT_FIND, bdll_pkg::ACT_READ, bdll_pkg::ACT_REMOVE,
      bdll_pkg::ACT_SIZE, ACT_UNUSED, bdll_pkg::ACT_CLEAR};

   typedef enum {MIX_GROW, MIX_CHURN, MIX_SHRINK} traffic_mix_type;

   typedef struct packed {
      logic [bdll_pkg::STATUS_W-1:0]       status;
      logic signed [bdll_pkg::VALUE_W-1:0] found_value;
      logic [bdll_pkg::POS_W-1:0]          found_position;
      logic [bdll_pkg::COUNT_W-1:0]        entry_count;
   } list_rsp_type;

   class list_scoreboard_type;
      logic signed [bdll_pkg::VALUE_W-1:0] entries[$];   // list contents, head first
      list_rsp_type expected[$];
      int mismatches;
      int responses_checked;

      function new();
         mismatches = 0;
         responses_checked = 0;
      endfunction

      function int list_size();
         return entries.size();
      endfunction

      function int pending();
         return expected.size();
      endfunction

      function logic signed [bdll_pkg::VALUE_W-1:0] sample_entry();
         return entries[$urandom_range(0, entries.size() - 1)];
      endfunction

      function void note_request(logic [bdll_pkg::ACTION_W-1:0] action,
                                 logic signed [bdll_pkg::VALUE_W-1:0] value,
                                 logic [bdll_pkg::POS_W-1:0] pos);
         list_rsp_type r;
         int match;
         r = '0;
         r.status = bdll_pkg::ST_OK;
         match = -1;
         case (action)
            bdll_pkg::ACT_APPEND, bdll_pkg::ACT_INSERT: begin
               if (entries.size() == CAPACITY)
                  r.status = bdll_pkg::ST_FULL;
               else if (action == bdll_pkg::ACT_APPEND)
                  entries.push_back(value);
               else
                  entries.push_front(value);
            end
            bdll_pkg::ACT_REMOVE, bdll_pkg::ACT_FIND: begin
               if (entries.size() == 0) begin
                  r.status = bdll_pkg::ST_EMPTY;
               end else begin
                  for (int i = 0; i < entries.size() && match < 0; i++)
                     if (entries[i] == value) match = i;
                  if (match < 0)
                     r.status = bdll_pkg::ST_NOT_FOUND;
                  else if (action == bdll_pkg::ACT_FIND)
                     r.found_position = bdll_pkg::POS_W'(match);
                  else
                     entries.delete(match);
               end
            end
            bdll_pkg::ACT_READ: begin
               if (entries.size() == 0)
                  r.status = bdll_pkg::ST_EMPTY;
               else if (pos >= entries.size())
                  r.status = bdll_pkg::ST_RANGE;
               else
                  r.found_value = entries[pos];
            end
            bdll_pkg::ACT_CLEAR: entries.delete();
            default: ;   // size and the unused code change nothing
         endcase
         r.entry_count = bdll_pkg::COUNT_W'(entries.size());
         expected.push_back(r);
      endfunction

      function void check_response(list_rsp_type got);
         list_rsp_type want;
         responses_checked++;
         if (expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: status %0d value %0d position %0d count %0d",
                        got.status, got.found_value, got.found_position, got.entry_count);
            return;
         end
         want = expected.pop_front();
         if (got.status !== want.status || got.found_value !== want.found_value ||
             got.found_position !== want.found_position ||
             got.entry_count !== want.entry_count) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response %0d mismatch", responses_checked);
               $display("  expected status %0d value %0d position %0d count %0d",
                        want.status, want.found_value, want.found_position, want.entry_count);
               $display("  actual   status %0d value %0d position %0d count %0d",
                        got.status, got.found_value, got.found_position, got.entry_count);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   bdll_req_if req_bus ();
   bdll_rsp_if rsp_bus ();

   bounded_doubly_linked_list_core #(.CAPACITY(CAPACITY)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   list_scoreboard_type sb = new();
   logic signed [bdll_pkg::VALUE_W-1:0] value_pool [8];
   int requests_sent = 0;
   bit sender_calm = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [bdll_pkg::VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 9) < 6) return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // remove and find mostly aim at values that are in the list
   function automatic logic signed [bdll_pkg::VALUE_W-1:0] pick_target();
      if (sb.list_size() > 0 && $urandom_range(0, 9) < 6) return sb.sample_entry();
      return pick_value();
   endfunction

   task automatic send_request(input logic [bdll_pkg::ACTION_W-1:0] action,
                               input logic signed [bdll_pkg::VALUE_W-1:0] value,
                               input logic [bdll_pkg::POS_W-1:0] pos);
      int gap;
      gap = sender_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.action     = action;
      req_bus.item_value = value;
      req_bus.position   = pos;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
      requests_sent++;
      if ($urandom_range(0, 49) == 0) sender_calm = !sender_calm;
   endtask

   task automatic random_request(input traffic_mix_type mix);
      int cut [7];
      int r;
      int n;
      logic [bdll_pkg::ACTION_W-1:0] action;
      logic signed [bdll_pkg::VALUE_W-1:0] value;
      logic [bdll_pkg::POS_W-1:0] pos;
      case (mix)
         MIX_GROW:  cut = '{40, 62, 72, 84, 92, 97, 99};
         MIX_CHURN: cut = '{20, 35, 53, 70, 90, 95, 98};
         default:   cut = '{8, 15, 30, 45, 90, 95, 99};
      endcase
      r = $urandom_range(0, 99);
      n = sb.list_size();
      action = MIX_ACTIONS[7];
      for (int i = 6; i >= 0; i--)
         if (r < cut[i]) action = MIX_ACTIONS[i];
      value = (action == bdll_pkg::ACT_REMOVE || action == bdll_pkg::ACT_FIND) ?
              pick_target() : pick_value();
      if (action == bdll_pkg::ACT_READ && n > 0 && $urandom_range(0, 9) < 7)
         pos = bdll_pkg::POS_W'($urandom_range(0, n - 1));
      else
         pos = bdll_pkg::POS_W'($urandom_range(0, 255));
      send_request(action, value, pos);
   endtask

   // fill the pool, then hit the full and longest-walk cases
   task automatic fill_list();
      while (sb.list_size() < CAPACITY)
         send_request($urandom_range(0, 1) ? bdll_pkg::ACT_APPEND : bdll_pkg::ACT_INSERT,
                      pick_value(), bdll_pkg::POS_W'($urandom_range(0, 255)));
      send_request(bdll_pkg::ACT_APPEND, pick_value(), 8'd0);
      send_request(bdll_pkg::ACT_INSERT, pick_value(), 8'd0);
      send_request(bdll_pkg::ACT_READ, 32'sd0, 8'd255);
      send_request(bdll_pkg::ACT_READ, 32'sd0, 8'd0);
      send_request(bdll_pkg::ACT_FIND, sb.entries[CAPACITY-1], 8'd0);
      send_request(bdll_pkg::ACT_SIZE, 32'sd0, 8'd0);
      send_request(bdll_pkg::ACT_REMOVE, sb.sample_entry(), 8'd0);
      send_request(bdll_pkg::ACT_APPEND, pick_value(), 8'd0);
   endtask

   always @(posedge clock) begin : monitor
      list_rsp_type seen;
      if (!reset) begin
         // response first: it belongs to an earlier request
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            seen.status         = rsp_bus.status;
            seen.found_value    = rsp_bus.found_value;
            seen.found_position = rsp_bus.found_position;
            seen.entry_count    = rsp_bus.entry_count;
            sb.check_response(seen);
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            sb.note_request(req_bus.action, req_bus.item_value, req_bus.position);
      end
   end

   initial begin : response_side
      int hold;
      bit calm;
      bit pressured;
      hold = 0;
      calm = 0;
      pressured = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!pressured && sb.responses_checked >= PRESSURE_AT) begin
            pressured = 1;
            hold = PRESSURE_HOLD;
         end
         if ($urandom_range(0, 99) == 0) calm = !calm;
         if (hold > 0) begin
            rsp_bus.ready = 1'b0;
            hold--;
         end else begin
            rsp_bus.ready = 1'b1;
            if (!calm) hold = pick_gap();
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            idle = 0;
         else
            idle++;
      end
      $display("bounded_doubly_linked_list_core verification failed");
      $finish;
   end

   initial begin : stimulus
      int directed_count;
      traffic_mix_type mix;
      bit filled;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.action     = bdll_pkg::ACT_SIZE;
      req_bus.item_value = '0;
      req_bus.position   = '0;
      filled = 0;
      value_pool[0] = VALUE_MIN;
      value_pool[1] = VALUE_MAX;
      value_pool[2] = 32'sd0;
      value_pool[3] = -32'sd1;
      for (int i = 4; i < 8; i++) value_pool[i] = $urandom;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty list answers
      send_request(bdll_pkg::ACT_SIZE, 32'sd0, 8'd0);
      send_request(bdll_pkg::ACT_REMOVE, 32'sd5, 8'd0);
      send_request(bdll_pkg::ACT_FIND, 32'sd5, 8'd0);
      send_request(bdll_pkg::ACT_READ, 32'sd0, 8'd0);
      send_request(ACT_UNUSED, 32'sd0, 8'd0);
      // list becomes -1, 0, min, max, max
      send_request(bdll_pkg::ACT_APPEND, VALUE_MIN, 8'd0);
      send_request(bdll_pkg::ACT_APPEND, VALUE_MAX, 8'd0);
      send_request(bdll_pkg::ACT_INSERT, 32'sd0, 8'd0);
      send_request(bdll_pkg::ACT_INSERT, -32'sd1, 8'd0);
      send_request(bdll_pkg::ACT_APPEND, VALUE_MAX, 8'd255);
      send_request(bdll_pkg::ACT_FIND, VALUE_MAX, 8'd0);
      send_request(bdll_pkg::ACT_FIND, 32'sd12345, 8'd0);
      send_request(bdll_pkg::ACT_READ, 32'sd0, 8'd0);
      send_request(bdll_pkg::ACT_READ, 32'sd0, 8'd4);
      send_request(bdll_pkg::ACT_READ, 32'sd0, 8'd5);
      send_request(bdll_pkg::ACT_READ, VALUE_MAX, 8'd255);
      // head, first of duplicates, tail, absent
      send_request(bdll_pkg::ACT_REMOVE, -32'sd1, 8'd0);
      send_request(bdll_pkg::ACT_REMOVE, VALUE_MAX, 8'd0);
      send_request(bdll_pkg::ACT_REMOVE, VALUE_MAX, 8'd0);
      send_request(bdll_pkg::ACT_REMOVE, 32'sd777, 8'd0);
      send_request(ACT_UNUSED, VALUE_MIN, 8'd255);
      send_request(bdll_pkg::ACT_REMOVE, VALUE_MIN, 8'd0);
      send_request(bdll_pkg::ACT_REMOVE, 32'sd0, 8'd0);
      // reuse after the list emptied, then clear
      send_request(bdll_pkg::ACT_APPEND, 32'sd42, 8'd0);
      send_request(bdll_pkg::ACT_READ, 32'sd0, 8'd0);
      send_request(bdll_pkg::ACT_CLEAR, 32'sd0, 8'd0);
      send_request(bdll_pkg::ACT_SIZE, 32'sd0, 8'd0);
      directed_count = requests_sent;

      while (requests_sent - directed_count < RANDOM_ITEMS) begin
         if (!filled && requests_sent - directed_count >= 300) begin
            fill_list();
            filled = 1;
         end
         mix = traffic_mix_type'($urandom_range(0, 2));
         repeat ($urandom_range(20, 80)) random_request(mix);
      end
      req_bus.valid = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (CAPACITY + 8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("bounded_doubly_linked_list_core verification clean");
      else
         $display("bounded_doubly_linked_list_core verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
sv/bdll_pkg.sv
sv/bdll_if.sv
sv/bounded_doubly_linked_list_core.sv
sim/bounded_doubly_linked_list_core_test.sv
